// ===== src/signed_int_to_seven_segment_defines.svh =====
// ============================================================================
// Assertion macros for signed_int_to_seven_segment
// Concurrent check wrappers; define ASSERT_OFF to compile them out.
// ============================================================================
`ifndef SIGNED_INT_TO_SEVEN_SEGMENT_DEFINES_SVH
`define SIGNED_INT_TO_SEVEN_SEGMENT_DEFINES_SVH

`ifndef ASSERT_OFF

// Same-cycle implication, disabled in reset
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("implication check failed");

// Next-cycle implication, disabled in reset
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

`else

`define ASSERT_IMPLY(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

// ===== src/s7seg_pkg.sv =====
`timescale 1ns / 1ps
// ============================================================================
// s7seg_pkg
// Shared types, constants and digit helpers of the seven-segment converter.
// ============================================================================
package s7seg_pkg;

   localparam int ValueWidth  = 16;
   localparam int MagWidth    = 14;   // saturated magnitude never exceeds 9999
   localparam int PairWidth   = 7;    // a value 0..99
   localparam int DigitWidth  = 4;
   localparam int SegWidth    = 8;
   localparam int CsrIdxWidth = 4;

   localparam logic signed [ValueWidth-1:0] ValueMax = 16'sd9999;
   localparam logic signed [ValueWidth-1:0] ValueMin = -16'sd999;

   // quotient by 100 as (mag * 5243) >> 19, exact for mag up to 9999
   localparam int ProdWidth     = 27;
   localparam int Recip100      = 5243;
   localparam int Recip100Shift = 19;
   // quotient by 10 as (x * 205) >> 11, exact for x up to 99
   localparam int Prod10Width   = 16;
   localparam int Recip10       = 205;
   localparam int Recip10Shift  = 11;

   localparam logic [MagWidth-1:0] Lim10   = 14'd10;
   localparam logic [MagWidth-1:0] Lim100  = 14'd100;
   localparam logic [MagWidth-1:0] Lim1000 = 14'd1000;

   localparam logic [SegWidth-1:0] BlankReset = 8'h00;
   localparam logic [SegWidth-1:0] MinusReset = 8'h40;
   localparam logic [SegWidth-1:0] SegZero    = 8'h3F;

   typedef enum logic [CsrIdxWidth-1:0] {
      CSR_BLANK_PATTERN = 4'd0,
      CSR_MINUS_PATTERN = 4'd1
   } csr_index_type;

   typedef struct packed {
      logic [SegWidth-1:0] blank_pattern;
      logic [SegWidth-1:0] minus_pattern;
   } cfg_type;

   typedef struct packed {
      logic [SegWidth-1:0] left;
      logic [SegWidth-1:0] mid_left;
      logic [SegWidth-1:0] mid_right;
      logic [SegWidth-1:0] right;
   } digits_type;

   typedef struct packed {
      logic [DigitWidth-1:0] tens;
      logic [DigitWidth-1:0] ones;
   } pair_type;

   // Split 0..99 into two decimal digits
   function automatic pair_type split_pair(input logic [PairWidth-1:0] x);
      logic [Prod10Width-1:0] prod;
      pair_type               res;
      prod     = Prod10Width'(x) * Prod10Width'(Recip10);
      res.tens = DigitWidth'(prod >> Recip10Shift);
      res.ones = DigitWidth'(x - PairWidth'(res.tens) * PairWidth'(10));
      return res;
   endfunction

   // Segment byte of a decimal numeral, bit0 = a .. bit6 = g
   function automatic logic [SegWidth-1:0] seg_of_digit(input logic [DigitWidth-1:0] d);
      logic [SegWidth-1:0] seg;
      case (d)
         4'd0:    seg = 8'h3F;
         4'd1:    seg = 8'h06;
         4'd2:    seg = 8'h5B;
         4'd3:    seg = 8'h4F;
         4'd4:    seg = 8'h66;
         4'd5:    seg = 8'h6D;
         4'd6:    seg = 8'h7D;
         4'd7:    seg = 8'h07;
         4'd8:    seg = 8'h7F;
         4'd9:    seg = 8'h6F;
         default: seg = 8'h00;
      endcase
      return seg;
   endfunction

endpackage

// ===== src/s7seg_csr.sv =====
`timescale 1ns / 1ps
// ============================================================================
// s7seg_csr
// Blank and minus segment pattern registers behind the write port.
// ============================================================================
module s7seg_csr
   import s7seg_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_valid,
   input  logic [CsrIdxWidth-1:0] csr_index,
   input  logic [SegWidth-1:0]    csr_data,
   output logic                   csr_ready,
   output cfg_type                cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign csr_ready = 1'b1;

   // unknown index: drop the write
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_BLANK_PATTERN: cfg_in.blank_pattern = csr_data;
            CSR_MINUS_PATTERN: cfg_in.minus_pattern = csr_data;
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.blank_pattern <= BlankReset;
         cfg_ff.minus_pattern <= MinusReset;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ===== src/s7seg_convert.sv =====
`timescale 1ns / 1ps
// ============================================================================
// s7seg_convert
// Saturate, split into decimal digits and map to display segment bytes.
// ============================================================================
module s7seg_convert
   import s7seg_pkg::*;
(
   input  logic signed [ValueWidth-1:0] value,
   input  cfg_type                      cfg,
   output digits_type                   digits
);

   logic signed [ValueWidth-1:0] sat;
   logic signed [ValueWidth-1:0] mag_wide;
   logic                         neg;
   logic [MagWidth-1:0]          mag;
   logic [ProdWidth-1:0]         prod;
   logic [PairWidth-1:0]         hi_pair;
   logic [PairWidth-1:0]         lo_pair;
   pair_type                     hi;
   pair_type                     lo;

   always_comb begin
      if (value > ValueMax) begin
         sat = ValueMax;
      end else if (value < ValueMin) begin
         sat = ValueMin;
      end else begin
         sat = value;
      end
      neg      = sat[ValueWidth-1];
      mag_wide = neg ? -sat : sat;
      mag      = mag_wide[MagWidth-1:0];
   end

   // hundreds pair and remainder pair
   assign prod    = ProdWidth'(mag) * ProdWidth'(Recip100);
   assign hi_pair = PairWidth'(prod >> Recip100Shift);
   assign lo_pair = PairWidth'(mag - MagWidth'(hi_pair) * MagWidth'(100));
   assign hi      = split_pair(hi_pair);
   assign lo      = split_pair(lo_pair);

   // rightmost always lit; minus leftmost if negative; others lit once reached
   always_comb begin
      digits.right     = seg_of_digit(lo.ones);
      digits.mid_right = (mag >= Lim10)  ? seg_of_digit(lo.tens) : cfg.blank_pattern;
      digits.mid_left  = (mag >= Lim100) ? seg_of_digit(hi.ones) : cfg.blank_pattern;
      if (neg) begin
         digits.left = cfg.minus_pattern;
      end else if (mag >= Lim1000) begin
         digits.left = seg_of_digit(hi.tens);
      end else begin
         digits.left = cfg.blank_pattern;
      end
   end

endmodule

// ===== src/signed_int_to_seven_segment.sv =====
`timescale 1ns / 1ps
// ============================================================================
// signed_int_to_seven_segment
// Signed 16-bit value to four seven-segment bytes, saturated to -999..9999.
// ============================================================================
// Path: a transferred request is held in the input register, then the
//   single conversion pass feeds the result register.
// Throughput: 1 item per cycle while the result channel is not stalled; set by the one-pass conversion between them.
// Reset: synchronous, active high; clears both stage valids, loads blank
//   pattern 0x00 and minus pattern 0x40.
`include "signed_int_to_seven_segment_defines.svh"

module signed_int_to_seven_segment
   import s7seg_pkg::*;
(
   input  logic                         clock,
   input  logic                         reset,
   // request channel
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic signed [ValueWidth-1:0] req_value,
   // result channel
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [SegWidth-1:0]          rsp_digit_left,
   output logic [SegWidth-1:0]          rsp_digit_mid_left,
   output logic [SegWidth-1:0]          rsp_digit_mid_right,
   output logic [SegWidth-1:0]          rsp_digit_right,
   // configuration write channel
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic [CsrIdxWidth-1:0]       csr_index,
   input  logic [SegWidth-1:0]          csr_data
);

   cfg_type cfg;

   // input stage
   logic                         in_valid_ff;
   logic                         in_valid_in;
   logic signed [ValueWidth-1:0] in_value_ff;
   logic signed [ValueWidth-1:0] in_value_in;

   // result stage
   logic       out_valid_ff;
   logic       out_valid_in;
   digits_type out_digits_ff;
   digits_type out_digits_in;
   digits_type conv_digits;

   logic advance_out;
   logic advance_in;

   s7seg_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .csr_ready (csr_ready),
      .cfg       (cfg)
   );

   s7seg_convert u_convert (
      .value  (in_value_ff),
      .cfg    (cfg),
      .digits (conv_digits)
   );

   // The result register advances when empty or when its transfer completes;
   // the input register advances when empty or when it can hand over. This
   // lets a new request land while a finished result still waits.
   assign advance_out = !out_valid_ff || !rsp_stall;
   assign advance_in  = !in_valid_ff || advance_out;
   assign req_stall   = !advance_in;

   always_comb begin
      in_valid_in   = in_valid_ff;
      in_value_in   = in_value_ff;
      out_valid_in  = out_valid_ff;
      out_digits_in = out_digits_ff;
      // advance the result stage: take the converted item or drain
      if (advance_out) begin
         out_valid_in  = in_valid_ff;
         out_digits_in = conv_digits;
      end
      // capture a new request on transfer, otherwise hold
      if (advance_in) begin
         in_valid_in = req_valid;
         in_value_in = req_value;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
      in_value_ff   <= in_value_in;
      out_digits_ff <= out_digits_in;
   end

   assign rsp_valid           = out_valid_ff;
   assign rsp_digit_left      = out_digits_ff.left;
   assign rsp_digit_mid_left  = out_digits_ff.mid_left;
   assign rsp_digit_mid_right = out_digits_ff.mid_right;
   assign rsp_digit_right     = out_digits_ff.right;

   // Both stages full with the result held: the request side must stall
   `ASSERT_IMPLY(a_full_stall, clock, reset, in_valid_ff && out_valid_ff && rsp_stall, req_stall)
   // A request transfer always lands in the input stage
   `ASSERT_NEXT(a_req_lands, clock, reset, req_valid && !req_stall, in_valid_ff)
   // An item handed over always shows up as a result
   `ASSERT_NEXT(a_handover, clock, reset, in_valid_ff && advance_out, rsp_valid)
   // Negative values carry the minus pattern leftmost
   `ASSERT_NEXT(a_minus_left, clock, reset, in_valid_ff && advance_out && in_value_ff[ValueWidth-1], rsp_digit_left == cfg.minus_pattern)
   // Zero shows the numeral 0 rightmost
   `ASSERT_NEXT(a_zero_right, clock, reset, in_valid_ff && advance_out && in_value_ff == '0, rsp_digit_right == SegZero)

endmodule

// ===== tb/sv/signed_int_to_seven_segment_tb.sv =====
`timescale 1ns / 1ps
// ============================================================================
// signed_int_to_seven_segment_tb
// Drives signed values through the seven-segment converter and checks each
// four-digit result against an in-bench model: saturation, alignment, blank
// and minus patterns, under random idling on both channels.
// ============================================================================
module signed_int_to_seven_segment_tb;
   import s7seg_pkg::*;

   localparam int WatchdogLimit = 4000;

   // Hold every input at a known value from time zero.
   logic                         clock     = 1'b0;
   logic                         reset     = 1'b1;
   logic                         req_valid = 1'b0;
   logic                         req_stall;
   logic signed [ValueWidth-1:0] req_value = '0;
   logic                         rsp_valid;
   logic                         rsp_stall = 1'b0;
   logic [SegWidth-1:0]          rsp_digit_left;
   logic [SegWidth-1:0]          rsp_digit_mid_left;
   logic [SegWidth-1:0]          rsp_digit_mid_right;
   logic [SegWidth-1:0]          rsp_digit_right;
   logic                         csr_valid = 1'b0;
   logic                         csr_ready;
   logic [CsrIdxWidth-1:0]       csr_index = '0;
   logic [SegWidth-1:0]          csr_data  = '0;

   // Set in the last phase: no idling on either side.
   bit          calm = 1'b0;
   int          idle_cycles = 0;
   digits_type  seen_digits;
   int          boundary_values [19] = '{0, 1, 9, 10, 99, 100, 999, 1000, 9999, 10000,
                                         32767, -1, -9, -10, -99, -100, -999, -1000,
                                         -32768};

   // -------------------------------------------------------------------------
   // Display model and queue of digit sets still owed by the block
   // -------------------------------------------------------------------------
   class digit_board;
      logic [SegWidth-1:0] blank_seg;
      logic [SegWidth-1:0] minus_seg;
      logic [SegWidth-1:0] numeral_segs [10];
      digits_type          pending_digits [$];
      int                  mismatches;

      function new();
         numeral_segs = '{8'h3F, 8'h06, 8'h5B, 8'h4F, 8'h66,
                          8'h6D, 8'h7D, 8'h07, 8'h7F, 8'h6F};
         blank_seg    = BlankReset;
         minus_seg    = MinusReset;
         mismatches   = 0;
      endfunction

      function void write_reg(logic [CsrIdxWidth-1:0] idx, logic [SegWidth-1:0] data);
         if (idx == CSR_BLANK_PATTERN) begin
            blank_seg = data;
         end else if (idx == CSR_MINUS_PATTERN) begin
            minus_seg = data;
         end
      endfunction

      function digits_type segments_for(logic signed [ValueWidth-1:0] value);
         int                  shown;
         int                  mag;
         int                  pos;
         int                  lowest;
         bit                  neg;
         logic [SegWidth-1:0] cells [4];
         digits_type          res;
         shown = value;
         if (shown > 9999) shown = 9999;
         if (shown < -999) shown = -999;
         neg    = shown < 0;
         mag    = neg ? -shown : shown;
         lowest = neg ? 1 : 0;
         foreach (cells[i]) cells[i] = blank_seg;
         // rightmost always shows a numeral, others only while digits remain
         cells[3] = numeral_segs[mag % 10];
         mag      = mag / 10;
         pos      = 2;
         while (mag != 0 && pos >= lowest) begin
            cells[pos] = numeral_segs[mag % 10];
            mag        = mag / 10;
            pos--;
         end
         if (neg) cells[0] = minus_seg;
         res.left      = cells[0];
         res.mid_left  = cells[1];
         res.mid_right = cells[2];
         res.right     = cells[3];
         return res;
      endfunction

      function void note_value(logic signed [ValueWidth-1:0] value);
         pending_digits.push_back(segments_for(value));
      endfunction

      function void compare_seg(string name, logic [SegWidth-1:0] want,
                                logic [SegWidth-1:0] got);
         if (got !== want) begin
            $display("%0t %s mismatch: expected %h, actual %h", $time, name, want, got);
            mismatches++;
         end
      endfunction

      function void check_digits(digits_type got);
         digits_type want;
         if (pending_digits.size() == 0) begin
            $display("%0t unexpected result: expected none, actual %h %h %h %h", $time,
                     got.left, got.mid_left, got.mid_right, got.right);
            mismatches++;
            return;
         end
         want = pending_digits.pop_front();
         compare_seg("digit_left", want.left, got.left);
         compare_seg("digit_mid_left", want.mid_left, got.mid_left);
         compare_seg("digit_mid_right", want.mid_right, got.mid_right);
         compare_seg("digit_right", want.right, got.right);
      endfunction
   endclass

   digit_board board = new();

   signed_int_to_seven_segment u_top (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_value           (req_value),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_digit_left      (rsp_digit_left),
      .rsp_digit_mid_left  (rsp_digit_mid_left),
      .rsp_digit_mid_right (rsp_digit_mid_right),
      .rsp_digit_right     (rsp_digit_right),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_index           (csr_index),
      .csr_data            (csr_data)
   );

   // 4 ns clock
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // -------------------------------------------------------------------------
   // Driving tasks: called at a falling edge, return at a falling edge
   // -------------------------------------------------------------------------

   // Issue one value; optionally drop valid for a random burst first. Valid
   // stays high on return so back-to-back transfers never toggle it.
   task automatic send_value(input logic signed [ValueWidth-1:0] value);
      int gap;
      gap = 0;
      if (!calm && $urandom_range(0, 5) == 0) gap = $urandom_range(1, 14);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_value <= value;
      // hold the payload until the transfer happens
      do @(posedge clock); while (req_stall);
      board.note_value(value);
      @(negedge clock);
   endtask

   // Register write; lower valid one step later so a following write
   // starts in a fresh time step.
   task automatic write_reg(input logic [CsrIdxWidth-1:0] idx,
                            input logic [SegWidth-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      board.write_reg(idx, data);
      @(negedge clock);
      csr_valid <= 1'b0;
      @(negedge clock);
   endtask

   // Lower valid, then wait for every owed result and let the pipeline settle.
   task automatic drain();
      req_valid <= 1'b0;
      @(negedge clock);
      while (board.pending_digits.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   // Mix of full-range noise, in-range values, values near zero and values
   // around every digit-count and saturation boundary.
   function automatic logic signed [ValueWidth-1:0] pick_value();
      int r;
      r = $urandom_range(0, 99);
      if (r < 30) return ValueWidth'($urandom);
      if (r < 65) return ValueWidth'(int'($urandom_range(0, 10998)) - 999);
      if (r < 80) return ValueWidth'(int'($urandom_range(0, 40)) - 20);
      return ValueWidth'(boundary_values[$urandom_range(0, 18)]
                         + int'($urandom_range(0, 4)) - 2);
   endfunction

   // -------------------------------------------------------------------------
   // Result side: random stall bursts, none once calm
   // -------------------------------------------------------------------------
   initial begin
      forever begin
         @(negedge clock);
         if (!calm && $urandom_range(0, 7) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(0, 13)) @(negedge clock);
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // Check every result transfer against the oldest owed digit set.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         seen_digits.left      = rsp_digit_left;
         seen_digits.mid_left  = rsp_digit_mid_left;
         seen_digits.mid_right = rsp_digit_mid_right;
         seen_digits.right     = rsp_digit_right;
         board.check_digits(seen_digits);
      end
   end

   // Abort when no channel has moved a transfer for too long.
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (csr_valid && csr_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WatchdogLimit) begin
         $display("FAIL");
         $finish;
      end
   end

   // -------------------------------------------------------------------------
   // Main sequence
   // -------------------------------------------------------------------------
   initial begin
      logic [SegWidth-1:0] blank_next;
      logic [SegWidth-1:0] minus_next;
      repeat (9) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed pass with reset patterns: edges of every digit count,
      // zero, both saturation limits and the 16-bit extremes.
      foreach (boundary_values[i]) send_value(ValueWidth'(boundary_values[i]));
      drain();

      // Random phases, each under a new pair of patterns; start with the
      // extremes, finish with a phase free of idling.
      for (int phase = 0; phase < 6; phase++) begin
         case (phase)
            0: begin
               blank_next = 8'hFF;
               minus_next = 8'h00;
            end
            1: begin
               blank_next = 8'h00;
               minus_next = 8'hFF;
            end
            default: begin
               blank_next = SegWidth'($urandom);
               minus_next = SegWidth'($urandom);
            end
         endcase
         write_reg(CSR_BLANK_PATTERN, blank_next);
         write_reg(CSR_MINUS_PATTERN, minus_next);
         // unused index must leave both patterns alone
         write_reg(CsrIdxWidth'($urandom_range(CSR_MINUS_PATTERN + 1,
                                               (1 << CsrIdxWidth) - 1)),
                   SegWidth'($urandom));
         if (phase == 5) calm = 1'b1;
         for (int n = 0; n < 64; n++) send_value(pick_value());
         drain();
      end

      repeat (8) @(negedge clock);
      if (board.mismatches == 0 && board.pending_digits.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
